// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker file of the interrupt entry block.
// No dependencies; take in by `include before use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain clocked property, switched off while reset is held.
`define IES_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("%m: property failed");

// A stalled beat keeps its payload into the next cycle.
`define IES_ASSERT_HOLD(lbl, clk, rstn, vld, rdy, sig) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) \
    (vld && !rdy) |=> (vld && $stable(sig))) \
    else $error("%m: stalled beat changed");

`endif

// ===== rtl/ies_pkg.sv =====
// Interrupt entry sequencer package: beat layouts, codes and the control store.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ies_pkg;

  localparam int IN_TDATA_W  = 136;
  localparam int OUT_TDATA_W = 160;

  // kinds of input beat
  localparam logic [2:0] K_REQ   = 3'd0;
  localparam logic [2:0] K_SVC   = 3'd1;
  localparam logic [2:0] K_WDONE = 3'd2;
  localparam logic [2:0] K_ACK   = 3'd3;
  localparam logic [2:0] K_READ  = 3'd4;

  // result status
  localparam logic [2:0] ST_NONE  = 3'd0;
  localparam logic [2:0] ST_WRITE = 3'd1;
  localparam logic [2:0] ST_ACK   = 3'd2;
  localparam logic [2:0] ST_READ  = 3'd3;
  localparam logic [2:0] ST_DONE  = 3'd4;
  localparam logic [2:0] ST_FAULT = 3'd5;
  localparam logic [2:0] ST_DROP  = 3'd6;

  // bus sequence phase
  localparam logic [2:0] PH_IDLE = 3'd0;
  localparam logic [2:0] PH_WPC  = 3'd1;
  localparam logic [2:0] PH_WSR  = 3'd2;
  localparam logic [2:0] PH_ACK  = 3'd3;
  localparam logic [2:0] PH_READ = 3'd4;

  // acknowledge reply vector kinds
  localparam logic [1:0] VK_GIVEN = 2'd0;
  localparam logic [1:0] VK_AUTO  = 2'd1;

  localparam logic [7:0]  VEC_AUTO_BASE = 8'd24;
  localparam logic [7:0]  VEC_SPURIOUS  = 8'd24;
  localparam logic [2:0]  LVL_MAX       = 3'd7;
  localparam logic [2:0]  LVL_MIN       = 3'd1;
  localparam logic [15:0] SR_KEEP       = 16'hf8ff;
  localparam logic [15:0] SR_S          = 16'h2000;
  localparam logic [15:0] SR_NO_T       = 16'h7fff;
  localparam logic [31:0] PUSH_PC_OFS   = 32'd4;
  localparam logic [31:0] PUSH_SR_OFS   = 32'd2;

  // datapath actions
  localparam logic [3:0] A_NOP  = 4'd0;
  localparam logic [3:0] A_REQ  = 4'd1;
  localparam logic [3:0] A_NULL = 4'd2;
  localparam logic [3:0] A_CLR  = 4'd3;
  localparam logic [3:0] A_SCAN = 4'd4;
  localparam logic [3:0] A_TAKE = 4'd5;
  localparam logic [3:0] A_WPC  = 4'd6;
  localparam logic [3:0] A_WSR  = 4'd7;
  localparam logic [3:0] A_ACK  = 4'd8;
  localparam logic [3:0] A_READ = 4'd9;

  // jump conditions
  localparam logic [1:0] C_NONE   = 2'd0;
  localparam logic [1:0] C_MORE   = 2'd1;
  localparam logic [1:0] C_MASKED = 2'd2;

  // control store addresses
  localparam int UPC_W = 4;
  localparam logic [UPC_W-1:0] U_REQ  = 4'd0;
  localparam logic [UPC_W-1:0] U_NULL = 4'd1;
  localparam logic [UPC_W-1:0] U_CLR  = 4'd2;
  localparam logic [UPC_W-1:0] U_SCAN = 4'd3;
  localparam logic [UPC_W-1:0] U_TEST = 4'd4;
  localparam logic [UPC_W-1:0] U_TAKE = 4'd5;
  localparam logic [UPC_W-1:0] U_WPC  = 4'd6;
  localparam logic [UPC_W-1:0] U_WSR  = 4'd7;
  localparam logic [UPC_W-1:0] U_ACK  = 4'd8;
  localparam logic [UPC_W-1:0] U_READ = 4'd9;

  typedef struct packed {
    logic [3:0]       act;
    logic [1:0]       cond;
    logic [UPC_W-1:0] tgt;
    logic             last;   // step emits the result beat
  } ies_cw_t;

  typedef struct packed {
    logic       fire;
    logic [3:0] act;
    logic       last;
  } ies_ctl_t;

  typedef struct packed {
    logic more;
    logic masked;
  } ies_cond_t;

  typedef struct packed {
    logic push;
    logic clr;
    logic scan;
    logic remove;
  } ies_qop_t;

  typedef struct packed {
    logic       full;
    logic       empty;
    logic       more;
    logic [2:0] best_lvl;
  } ies_qstat_t;

  // input beat tdata, last member in the lowest bits
  typedef struct packed {
    logic [7:0]  vector_number;
    logic [1:0]  vector_kind;
    logic [31:0] read_data;
    logic        bus_ok;
    logic        is_stopped;
    logic [31:0] cur_ssp;
    logic [31:0] cur_pc;
    logic [15:0] cur_sr;
    logic [7:0]  req_source;
    logic [3:0]  req_level;
  } ies_in_t;

  // result beat tdata
  typedef struct packed {
    logic [2:0]  pad;
    logic        wake;
    logic [31:0] new_ssp;
    logic [15:0] new_sr;
    logic [31:0] new_pc;
    logic [7:0]  ack_source;
    logic [2:0]  ack_level;
    logic        bus_is_word;
    logic [31:0] bus_data;
    logic [31:0] bus_address;
  } ies_out_t;

  function automatic ies_cw_t ucode(input logic [UPC_W-1:0] upc);
    ies_cw_t cw;
    cw = '{act: A_NULL, cond: C_NONE, tgt: U_NULL, last: 1'b1};
    case (upc)
      U_REQ:  cw = '{act: A_REQ,  cond: C_NONE,   tgt: U_NULL, last: 1'b1};
      U_NULL: cw = '{act: A_NULL, cond: C_NONE,   tgt: U_NULL, last: 1'b1};
      U_CLR:  cw = '{act: A_CLR,  cond: C_NONE,   tgt: U_NULL, last: 1'b0};
      U_SCAN: cw = '{act: A_SCAN, cond: C_MORE,   tgt: U_SCAN, last: 1'b0};
      U_TEST: cw = '{act: A_NOP,  cond: C_MASKED, tgt: U_NULL, last: 1'b0};
      U_TAKE: cw = '{act: A_TAKE, cond: C_NONE,   tgt: U_NULL, last: 1'b1};
      U_WPC:  cw = '{act: A_WPC,  cond: C_NONE,   tgt: U_NULL, last: 1'b1};
      U_WSR:  cw = '{act: A_WSR,  cond: C_NONE,   tgt: U_NULL, last: 1'b1};
      U_ACK:  cw = '{act: A_ACK,  cond: C_NONE,   tgt: U_NULL, last: 1'b1};
      U_READ: cw = '{act: A_READ, cond: C_NONE,   tgt: U_NULL, last: 1'b1};
      default: cw = '{act: A_NULL, cond: C_NONE,  tgt: U_NULL, last: 1'b1};
    endcase
    return cw;
  endfunction

  // entry point of the routine for an accepted beat
  function automatic logic [UPC_W-1:0] dispatch(input logic [2:0] kind,
                                                input logic [2:0] phase,
                                                input logic       empty);
    logic [UPC_W-1:0] u;
    u = U_NULL;
    case (kind)
      K_REQ:   u = U_REQ;
      K_SVC:   u = (phase == PH_IDLE && !empty) ? U_CLR : U_NULL;
      K_WDONE: u = (phase == PH_WPC) ? U_WPC : ((phase == PH_WSR) ? U_WSR : U_NULL);
      K_ACK:   u = (phase == PH_ACK) ? U_ACK : U_NULL;
      K_READ:  u = (phase == PH_READ) ? U_READ : U_NULL;
      default: u = U_NULL;
    endcase
    return u;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/interrupt_entry_sequencer.sv =====
// Interrupt entry sequencer top level: beat capture, entry datapath, result register.
// Depends on ies_pkg, ies_useq and ies_queue.
//
//  channel | group                  | direction | contents
//  --------+------------------------+-----------+----------------------------------
//  in_     | tvalid tready tuser tdata | slave  | request, service attempt, bus replies
//  out_    | tvalid tready tuser tdata | master | one status beat per input beat
//
// Cycles: a beat is taken when the sequencer is free and runs through the
// microprogram; requests and bus replies need one step, a service attempt
// one or, in phase idle with N >= 1 pending, 3 + N steps (the scan reads one
// entry a cycle). The next beat is taken in the cycle after the result step.
// Reset: synchronous, active low; queue empty, phase idle, no beat held.
// Stalls: a held result only blocks the next result step; a beat may still
// be taken and its non-result steps run meanwhile.
`timescale 1ns / 1ps
`default_nettype none

module interrupt_entry_sequencer #(
  parameter int QUEUE_DEPTH = 8,
  parameter int SOURCE_BITS = 8
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_tvalid,
  output logic                                    in_tready,
  // kind [2:0]
  input  wire logic [2:0]                         in_tuser,
  // req_level [3:0], req_source [11:4], cur_sr [27:12], cur_pc [59:28],
  // cur_ssp [91:60], is_stopped [92], bus_ok [93], read_data [125:94],
  // vector_kind [127:126], vector_number [135:128]
  input  wire logic [ies_pkg::IN_TDATA_W-1:0]     in_tdata,
  output logic                                    out_tvalid,
  input  wire logic                               out_tready,
  // status [2:0]
  output logic [2:0]                              out_tuser,
  // bus_address [31:0], bus_data [63:32], bus_is_word [64], ack_level [67:65],
  // ack_source [75:68], new_pc [107:76], new_sr [123:108], new_ssp [155:124],
  // wake [156], zero [159:157]
  output logic [ies_pkg::OUT_TDATA_W-1:0]         out_tdata
);

  localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  // captured beat
  ies_pkg::ies_in_t  item_r;

  // entry state
  logic [2:0]             phase_r, phase_nxt;
  logic [15:0]            saved_sr_r, saved_sr_nxt;
  logic [31:0]            saved_pc_r, saved_pc_nxt;
  logic [15:0]            work_sr_r, work_sr_nxt;
  logic [31:0]            work_ssp_r, work_ssp_nxt;
  logic [2:0]             chosen_lvl_r, chosen_lvl_nxt;
  logic [SOURCE_BITS-1:0] chosen_src_r, chosen_src_nxt;
  logic [IDX_W-1:0]       chosen_slot_r, chosen_slot_nxt;

  // result register
  logic              out_valid_r;
  logic [2:0]        out_st_r;
  ies_pkg::ies_out_t out_data_r;
  logic [2:0]        st_nxt;
  ies_pkg::ies_out_t res_nxt;
  logic              out_free;

  // control
  logic                       accept;
  logic                       idle;
  logic [ies_pkg::UPC_W-1:0]  entry;
  ies_pkg::ies_ctl_t          ctl;
  ies_pkg::ies_cond_t         cond;
  ies_pkg::ies_qop_t          q_op;
  ies_pkg::ies_qstat_t        q_stat;
  logic [IDX_W-1:0]           q_best_slot;
  logic [SOURCE_BITS-1:0]     q_best_src;

  // datapath helpers
  logic [2:0]             req_lvl;
  logic [15:0]            req_src_ext;
  logic [SOURCE_BITS-1:0] req_src;
  logic [15:0]            ack_src_ext;
  logic [2:0]             sr_mask;
  logic [7:0]             vec;
  logic [31:0]            ssp_wpc;
  logic [31:0]            ssp_wsr;

  assign in_tready = idle;
  assign accept    = in_tvalid && idle;
  assign out_free  = !out_valid_r || out_tready;
  assign entry     = ies_pkg::dispatch(in_tuser, phase_r, q_stat.empty);

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= ies_pkg::ies_in_t'(in_tdata);
    end
  end

  ies_useq u_useq (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (accept),
    .entry    (entry),
    .cond     (cond),
    .out_free (out_free),
    .ctl      (ctl),
    .idle     (idle)
  );

  ies_queue #(
    .DEPTH (QUEUE_DEPTH),
    .SRC_W (SOURCE_BITS),
    .IDX_W (IDX_W),
    .CNT_W (CNT_W)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .op        (q_op),
    .push_lvl  (req_lvl),
    .push_src  (req_src),
    .rm_slot   (chosen_slot_r),
    .stat      (q_stat),
    .best_slot (q_best_slot),
    .best_src  (q_best_src)
  );

  // level clamped into 1..7
  always_comb begin
    if (item_r.req_level > 4'(ies_pkg::LVL_MAX)) begin
      req_lvl = ies_pkg::LVL_MAX;
    end else if (item_r.req_level < 4'(ies_pkg::LVL_MIN)) begin
      req_lvl = ies_pkg::LVL_MIN;
    end else begin
      req_lvl = item_r.req_level[2:0];
    end
  end

  assign req_src_ext = 16'(item_r.req_source);
  assign req_src     = req_src_ext[SOURCE_BITS-1:0];
  assign ack_src_ext = 16'(chosen_src_r);

  // level 7 is never masked
  assign sr_mask     = item_r.cur_sr[10:8];
  assign cond.more   = q_stat.more;
  assign cond.masked = (q_stat.best_lvl <= sr_mask) && (q_stat.best_lvl != ies_pkg::LVL_MAX);

  assign ssp_wpc = item_r.cur_ssp - ies_pkg::PUSH_PC_OFS;
  assign ssp_wsr = work_ssp_r - ies_pkg::PUSH_SR_OFS;

  always_comb begin
    case (item_r.vector_kind)
      ies_pkg::VK_GIVEN: vec = item_r.vector_number;
      ies_pkg::VK_AUTO:  vec = ies_pkg::VEC_AUTO_BASE + 8'(chosen_lvl_r);
      default:           vec = ies_pkg::VEC_SPURIOUS;
    endcase
  end

  always_comb begin
    phase_nxt       = phase_r;
    saved_sr_nxt    = saved_sr_r;
    saved_pc_nxt    = saved_pc_r;
    work_sr_nxt     = work_sr_r;
    work_ssp_nxt    = work_ssp_r;
    chosen_lvl_nxt  = chosen_lvl_r;
    chosen_src_nxt  = chosen_src_r;
    chosen_slot_nxt = chosen_slot_r;
    st_nxt          = ies_pkg::ST_NONE;
    res_nxt         = '0;
    q_op            = '0;
    if (ctl.fire) begin
      case (ctl.act)
        ies_pkg::A_REQ: begin
          if (q_stat.full) begin
            st_nxt = ies_pkg::ST_DROP;
          end else begin
            q_op.push = 1'b1;
          end
        end
        ies_pkg::A_CLR: begin
          q_op.clr = 1'b1;
        end
        ies_pkg::A_SCAN: begin
          q_op.scan = 1'b1;
        end
        ies_pkg::A_TAKE: begin
          chosen_slot_nxt     = q_best_slot;
          chosen_lvl_nxt      = q_stat.best_lvl;
          chosen_src_nxt      = q_best_src;
          saved_sr_nxt        = item_r.cur_sr;
          saved_pc_nxt        = item_r.cur_pc;
          // new mask, S set, T cleared
          work_sr_nxt         = ((item_r.cur_sr & ies_pkg::SR_KEEP)
                                | {5'b0, q_stat.best_lvl, 8'b0}
                                | ies_pkg::SR_S) & ies_pkg::SR_NO_T;
          work_ssp_nxt        = ssp_wpc;
          phase_nxt           = ies_pkg::PH_WPC;
          st_nxt              = ies_pkg::ST_WRITE;
          res_nxt.bus_address = ssp_wpc;
          res_nxt.bus_data    = item_r.cur_pc;
          res_nxt.wake        = item_r.is_stopped;
        end
        ies_pkg::A_WPC: begin
          if (item_r.bus_ok) begin
            work_ssp_nxt        = ssp_wsr;
            phase_nxt           = ies_pkg::PH_WSR;
            st_nxt              = ies_pkg::ST_WRITE;
            res_nxt.bus_address = ssp_wsr;
            res_nxt.bus_data    = 32'(saved_sr_r);
            res_nxt.bus_is_word = 1'b1;
          end else begin
            phase_nxt = ies_pkg::PH_IDLE;
            st_nxt    = ies_pkg::ST_FAULT;
          end
        end
        ies_pkg::A_WSR: begin
          if (item_r.bus_ok) begin
            phase_nxt          = ies_pkg::PH_ACK;
            st_nxt             = ies_pkg::ST_ACK;
            res_nxt.ack_level  = chosen_lvl_r;
            res_nxt.ack_source = ack_src_ext[7:0];
          end else begin
            phase_nxt = ies_pkg::PH_IDLE;
            st_nxt    = ies_pkg::ST_FAULT;
          end
        end
        ies_pkg::A_ACK: begin
          phase_nxt           = ies_pkg::PH_READ;
          st_nxt              = ies_pkg::ST_READ;
          res_nxt.bus_address = {22'b0, vec, 2'b00};
        end
        ies_pkg::A_READ: begin
          phase_nxt = ies_pkg::PH_IDLE;
          if (item_r.bus_ok) begin
            st_nxt          = ies_pkg::ST_DONE;
            res_nxt.new_pc  = item_r.read_data;
            res_nxt.new_sr  = work_sr_r;
            res_nxt.new_ssp = work_ssp_r;
            q_op.remove     = 1'b1;
          end else begin
            st_nxt = ies_pkg::ST_FAULT;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= ies_pkg::PH_IDLE;
      chosen_slot_r <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      phase_r       <= phase_nxt;
      chosen_slot_r <= chosen_slot_nxt;
      if (ctl.fire && ctl.last) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    saved_sr_r   <= saved_sr_nxt;
    saved_pc_r   <= saved_pc_nxt;
    work_sr_r    <= work_sr_nxt;
    work_ssp_r   <= work_ssp_nxt;
    chosen_lvl_r <= chosen_lvl_nxt;
    chosen_src_r <= chosen_src_nxt;
    if (ctl.fire && ctl.last) begin
      out_st_r   <= st_nxt;
      out_data_r <= res_nxt;
    end
  end

  // routine for a beat of unknown kind also lands on the null step
  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_st_r;
  assign out_tdata  = out_data_r;

endmodule

`default_nettype wire

// ===== rtl/ies_useq.sv =====
// Micro-sequencer: step counter over the control store, conditional jumps.
// Depends on ies_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ies_useq (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  input  wire logic [ies_pkg::UPC_W-1:0]   entry,
  input  wire ies_pkg::ies_cond_t          cond,
  input  wire logic                        out_free,
  output ies_pkg::ies_ctl_t                ctl,
  output logic                             idle
);

  logic                      busy_r, busy_nxt;
  logic [ies_pkg::UPC_W-1:0] upc_r, upc_nxt;
  ies_pkg::ies_cw_t          cw;
  logic                      fire;
  logic                      take_jump;

  assign cw   = ies_pkg::ucode(upc_r);
  // a result step waits for the output register
  assign fire = busy_r && (!cw.last || out_free);

  always_comb begin
    case (cw.cond)
      ies_pkg::C_MORE:   take_jump = cond.more;
      ies_pkg::C_MASKED: take_jump = cond.masked;
      default:           take_jump = 1'b0;
    endcase
  end

  always_comb begin
    busy_nxt = busy_r;
    upc_nxt  = upc_r;
    if (start) begin
      busy_nxt = 1'b1;
      upc_nxt  = entry;
    end else if (fire) begin
      if (cw.last) begin
        busy_nxt = 1'b0;
      end else if (take_jump) begin
        upc_nxt = cw.tgt;
      end else begin
        upc_nxt = upc_r + ies_pkg::UPC_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      upc_r  <= ies_pkg::U_NULL;
    end else begin
      busy_r <= busy_nxt;
      upc_r  <= upc_nxt;
    end
  end

  assign ctl  = '{fire: fire, act: cw.act, last: cw.last};
  assign idle = !busy_r;

endmodule

`default_nettype wire

// ===== rtl/ies_queue.sv =====
// Pending request queue: append, one-entry-a-cycle priority scan, shift-down removal.
// Depends on ies_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ies_queue #(
  parameter int DEPTH = 8,
  parameter int SRC_W = 8,
  parameter int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  parameter int CNT_W = $clog2(DEPTH + 1)
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire ies_pkg::ies_qop_t    op,
  input  wire logic [2:0]           push_lvl,
  input  wire logic [SRC_W-1:0]     push_src,
  input  wire logic [IDX_W-1:0]     rm_slot,
  output ies_pkg::ies_qstat_t       stat,
  output logic [IDX_W-1:0]          best_slot,
  output logic [SRC_W-1:0]          best_src
);

  logic [2:0]       lvl_q [DEPTH];
  logic [SRC_W-1:0] src_q [DEPTH];
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [IDX_W-1:0] idx_r;
  logic [2:0]       best_lvl_r;
  logic [IDX_W-1:0] best_slot_r;
  logic [SRC_W-1:0] best_src_r;
  logic             full;
  logic             do_push;
  logic             do_rm;
  logic [2:0]       scan_lvl;
  logic [SRC_W-1:0] scan_src;

  assign full     = (count_r == CNT_W'(DEPTH));
  assign do_push  = op.push && !full;
  assign do_rm    = op.remove && (count_r != '0);
  assign scan_lvl = lvl_q[idx_r];
  assign scan_src = src_q[idx_r];

  always_comb begin
    count_nxt = count_r;
    if (do_push) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (do_rm) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  // entry storage, no reset: only entries below the count are read
  always_ff @(posedge clk) begin
    for (int i = 0; i < DEPTH; i++) begin
      if (do_push && count_r[IDX_W-1:0] == IDX_W'(i)) begin
        lvl_q[i] <= push_lvl;
        src_q[i] <= push_src;
      end else if (do_rm && IDX_W'(i) >= rm_slot && i + 1 < DEPTH) begin
        lvl_q[i] <= lvl_q[(i + 1 < DEPTH) ? i + 1 : i];
        src_q[i] <= src_q[(i + 1 < DEPTH) ? i + 1 : i];
      end
    end
  end

  // scan: strict compare keeps the oldest of equal levels
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      idx_r       <= '0;
      best_lvl_r  <= '0;
      best_slot_r <= '0;
    end else begin
      count_r <= count_nxt;
      if (op.clr) begin
        idx_r       <= '0;
        best_lvl_r  <= '0;
        best_slot_r <= '0;
      end else if (op.scan) begin
        idx_r <= idx_r + IDX_W'(1);
        if (scan_lvl > best_lvl_r) begin
          best_lvl_r  <= scan_lvl;
          best_slot_r <= idx_r;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (op.scan && scan_lvl > best_lvl_r) begin
      best_src_r <= scan_src;
    end
  end

  assign stat.full     = full;
  assign stat.empty    = (count_r == '0);
  assign stat.more     = (CNT_W'(idx_r) + CNT_W'(1)) < count_r;
  assign stat.best_lvl = best_lvl_r;
  assign best_slot     = best_slot_r;
  assign best_src      = best_src_r;

endmodule

`default_nettype wire

// ===== rtl/ies_checker.sv =====
// Port-level checks for interrupt_entry_sequencer, attached by bind.
// Depends on ies_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module ies_checker (
  input wire logic                               clk,
  input wire logic                               rst_n,
  input wire logic                               in_tvalid,
  input wire logic                               in_tready,
  input wire logic                               out_tvalid,
  input wire logic                               out_tready,
  input wire logic [2:0]                         out_tuser,
  input wire logic [ies_pkg::OUT_TDATA_W-1:0]    out_tdata
);

  logic [ies_pkg::OUT_TDATA_W+2:0] out_beat;
  logic                            no_payload;
  logic                            pc_push;
  logic                            is_read;
  logic                            vec_addr_ok;

  assign out_beat    = {out_tuser, out_tdata};
  assign no_payload  = (out_tuser == ies_pkg::ST_NONE) || (out_tuser == ies_pkg::ST_FAULT)
                     || (out_tuser == ies_pkg::ST_DROP);
  assign pc_push     = (out_tuser == ies_pkg::ST_WRITE) && !out_tdata[64];
  assign is_read     = (out_tuser == ies_pkg::ST_READ);
  assign vec_addr_ok = (out_tdata[1:0] == 2'b00) && (out_tdata[31:10] == '0)
                     && (out_tdata[159:32] == '0);

  `IES_ASSERT_HOLD(a_out_hold, clk, rst_n, out_tvalid, out_tready, out_beat)

  // one beat at a time: the input closes straight after a take
  `IES_ASSERT(a_in_closes, clk, rst_n, (in_tvalid && in_tready) |=> !in_tready)

  // statuses without payload carry all-zero data
  `IES_ASSERT(a_empty_payload, clk, rst_n, (out_tvalid && no_payload) |-> (out_tdata == '0))

  // wake only on the PC push
  `IES_ASSERT(a_wake_on_pc_push, clk, rst_n, (out_tvalid && out_tdata[156]) |-> pc_push)

  // vector read address is a table slot, nothing else set
  `IES_ASSERT(a_vector_addr, clk, rst_n, (out_tvalid && is_read) |-> vec_addr_ok)

endmodule

bind interrupt_entry_sequencer ies_checker u_ies_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tuser  (out_tuser),
  .out_tdata  (out_tdata)
);

`default_nettype wire

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for interrupt_entry_sequencer: drives request, service and bus reply
// beats and checks every status beat against a cycle-free model of the entry sequence.
// Depends on ies_pkg and the interrupt_entry_sequencer RTL.

module tb;

  localparam int          QDEPTH      = 8;
  localparam logic [2:0]  K_UNUSED_HI = 3'd7;   // kinds 5..7 carry no meaning
  localparam int unsigned RUN_BEATS   = 750;

  // expected status beat: tuser status plus the tdata fields
  typedef struct packed {
    logic [2:0]        status;
    ies_pkg::ies_out_t body;
  } status_beat_t;

  // Tracks the pending queue and bus sequence; one expected status beat per input beat.
  class entry_tracker;
    logic [2:0]   lvl_q[QDEPTH];
    logic [7:0]   src_q[QDEPTH];
    int unsigned  fill;
    logic [2:0]   phase;
    int unsigned  pick;
    logic [15:0]  sr_saved;
    logic [15:0]  sr_entry;
    logic [31:0]  pc_saved;
    logic [31:0]  ssp_work;
    logic [7:0]   vector;
    status_beat_t status_due[$];
    int unsigned  errors, beats, effective, n_done, n_fault, n_drop, n_quiet_svc;

    function new();
      foreach (lvl_q[i]) begin
        lvl_q[i] = '0;
        src_q[i] = '0;
      end
      fill = 0;
      phase = ies_pkg::PH_IDLE;
      pick = 0;
      sr_saved = '0;
      sr_entry = '0;
      pc_saved = '0;
      ssp_work = '0;
      vector = '0;
      errors = 0;
      beats = 0;
      effective = 0;
      n_done = 0;
      n_fault = 0;
      n_drop = 0;
      n_quiet_svc = 0;
    endfunction

    function void note_beat(logic [2:0] kind, ies_pkg::ies_in_t d);
      status_beat_t r;
      logic [2:0]   lvl, best_lvl, held_lvl;
      int unsigned  best;
      logic         effect;
      r = '0;
      effect = 1'b0;
      beats++;
      held_lvl = lvl_q[pick];
      case (kind)
        ies_pkg::K_REQ: begin
          effect = 1'b1;
          if (d.req_level > 4'd7) lvl = ies_pkg::LVL_MAX;
          else if (d.req_level == 4'd0) lvl = ies_pkg::LVL_MIN;
          else lvl = d.req_level[2:0];
          if (fill < QDEPTH) begin
            lvl_q[fill] = lvl;
            src_q[fill] = d.req_source;
            fill++;
          end else begin
            r.status = ies_pkg::ST_DROP;
          end
        end
        ies_pkg::K_SVC: begin
          if (phase == ies_pkg::PH_IDLE && fill != 0) begin
            best = 0;
            best_lvl = '0;
            // strict compare: ties stay with the oldest entry
            for (int i = 0; i < int'(fill); i++) begin
              if (lvl_q[i] > best_lvl) begin
                best_lvl = lvl_q[i];
                best = unsigned'(i);
              end
            end
            // masked when not above SR mask; level 7 always gets through
            if (best_lvl > d.cur_sr[10:8] || best_lvl == ies_pkg::LVL_MAX) begin
              pick = best;
              sr_saved = d.cur_sr;
              pc_saved = d.cur_pc;
              sr_entry = ((d.cur_sr & ies_pkg::SR_KEEP) | {5'd0, best_lvl, 8'd0}
                         | ies_pkg::SR_S) & ies_pkg::SR_NO_T;
              ssp_work = d.cur_ssp - ies_pkg::PUSH_PC_OFS;
              phase = ies_pkg::PH_WPC;
              r.status = ies_pkg::ST_WRITE;
              r.body.bus_address = ssp_work;
              r.body.bus_data = pc_saved;
              r.body.wake = d.is_stopped;
            end
          end
          if (r.status == ies_pkg::ST_NONE) n_quiet_svc++;
        end
        ies_pkg::K_WDONE: begin
          if (phase == ies_pkg::PH_WPC || phase == ies_pkg::PH_WSR) begin
            if (!d.bus_ok) begin
              phase = ies_pkg::PH_IDLE;
              r.status = ies_pkg::ST_FAULT;
            end else if (phase == ies_pkg::PH_WPC) begin
              ssp_work = ssp_work - ies_pkg::PUSH_SR_OFS;
              phase = ies_pkg::PH_WSR;
              r.status = ies_pkg::ST_WRITE;
              r.body.bus_address = ssp_work;
              r.body.bus_data = {16'd0, sr_saved};
              r.body.bus_is_word = 1'b1;
            end else begin
              phase = ies_pkg::PH_ACK;
              r.status = ies_pkg::ST_ACK;
              r.body.ack_level = held_lvl;
              r.body.ack_source = src_q[pick];
            end
          end
        end
        ies_pkg::K_ACK: begin
          if (phase == ies_pkg::PH_ACK) begin
            case (d.vector_kind)
              ies_pkg::VK_GIVEN: vector = d.vector_number;
              ies_pkg::VK_AUTO:  vector = ies_pkg::VEC_AUTO_BASE + 8'(held_lvl);
              default:  vector = ies_pkg::VEC_SPURIOUS;   // spurious, and the unused fourth code
            endcase
            phase = ies_pkg::PH_READ;
            r.status = ies_pkg::ST_READ;
            r.body.bus_address = {22'd0, vector, 2'b00};
          end
        end
        ies_pkg::K_READ: begin
          if (phase == ies_pkg::PH_READ) begin
            phase = ies_pkg::PH_IDLE;
            if (!d.bus_ok) begin
              r.status = ies_pkg::ST_FAULT;
            end else begin
              r.status = ies_pkg::ST_DONE;
              r.body.new_pc = d.read_data;
              r.body.new_sr = sr_entry;
              r.body.new_ssp = ssp_work;
              // entry leaves the queue only now
              for (int i = int'(pick); i + 1 < int'(fill); i++) begin
                lvl_q[i] = lvl_q[i + 1];
                src_q[i] = src_q[i + 1];
              end
              fill--;
            end
          end
        end
        default: ;
      endcase
      case (r.status)
        ies_pkg::ST_DONE:  n_done++;
        ies_pkg::ST_FAULT: n_fault++;
        ies_pkg::ST_DROP:  n_drop++;
        default: ;
      endcase
      if (effect || r.status != ies_pkg::ST_NONE) effective++;
      status_due = {status_due, r};
    endfunction

    function void same(string field, logic [31:0] want, logic [31:0] seen);
      if (seen !== want) begin
        errors++;
        $display("%0t ns: %s expected %h, got %h", $time, field, want, seen);
      end
    endfunction

    function void check_beat(logic [2:0] st, ies_pkg::ies_out_t got);
      status_beat_t e;
      if (status_due.size() == 0) begin
        errors++;
        $display("%0t ns: status beat %0d with nothing outstanding", $time, st);
        return;
      end
      e = status_due.pop_front();
      same("status", 32'(e.status), 32'(st));
      same("bus_address", e.body.bus_address, got.bus_address);
      same("bus_data", e.body.bus_data, got.bus_data);
      same("bus_is_word", 32'(e.body.bus_is_word), 32'(got.bus_is_word));
      same("ack_level", 32'(e.body.ack_level), 32'(got.ack_level));
      same("ack_source", 32'(e.body.ack_source), 32'(got.ack_source));
      same("new_pc", e.body.new_pc, got.new_pc);
      same("new_sr", 32'(e.body.new_sr), 32'(got.new_sr));
      same("new_ssp", e.body.new_ssp, got.new_ssp);
      same("wake", 32'(e.body.wake), 32'(got.wake));
      same("pad", 32'(e.body.pad), 32'(got.pad));
    endfunction
  endclass

  logic                            clk = 1'b0;
  logic                            rst_n;
  logic                            in_tvalid;
  logic                            in_tready;
  logic [2:0]                      in_tuser;
  logic [ies_pkg::IN_TDATA_W-1:0]  in_tdata;
  logic                            out_tvalid;
  logic                            out_tready;
  logic [2:0]                      out_tuser;
  logic [ies_pkg::OUT_TDATA_W-1:0] out_tdata;

  entry_tracker sb;
  int unsigned  burst_left = 0;
  int unsigned  stall_mode = 0;
  int unsigned  stall_left = 0;
  int unsigned  mode_age = 0;

  interrupt_entry_sequencer DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tuser  (out_tuser),
    .out_tdata  (out_tdata)
  );

  always #5 clk = ~clk;

  // both sides sampled at the rising edge; stimulus only moves at the falling edge
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) sb.note_beat(in_tuser, ies_pkg::ies_in_t'(in_tdata));
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      sb.check_beat(out_tuser, ies_pkg::ies_out_t'(out_tdata));
    end
  end

  // receiver back-pressure: free-running, random stalls or long on/off stretches
  always @(negedge clk) begin
    if (mode_age == 0) begin
      stall_mode = $urandom_range(0, 2);
      mode_age = $urandom_range(32, 160);
    end
    mode_age--;
    case (stall_mode)
      0: out_tready = 1'b1;
      1: out_tready = ($urandom_range(0, 2) != 0);
      default: begin
        if (stall_left == 0) begin
          out_tready = ~out_tready;
          stall_left = out_tready ? $urandom_range(1, 4) : $urandom_range(1, 8);
        end
        stall_left--;
      end
    endcase
  end

  // every field random, callers override the ones that matter
  function automatic ies_pkg::ies_in_t random_fields();
    ies_pkg::ies_in_t d;
    d.req_level = 4'($urandom);
    d.req_source = 8'($urandom);
    d.cur_sr = 16'($urandom);
    d.cur_pc = $urandom;
    d.cur_ssp = $urandom;
    d.is_stopped = 1'($urandom);
    d.bus_ok = 1'($urandom);
    d.read_data = $urandom;
    d.vector_kind = 2'($urandom);
    d.vector_number = 8'($urandom);
    return d;
  endfunction

  function automatic ies_pkg::ies_in_t mk_req(logic [3:0] level, logic [7:0] src);
    ies_pkg::ies_in_t d;
    d = random_fields();
    d.req_level = level;
    d.req_source = src;
    return d;
  endfunction

  function automatic ies_pkg::ies_in_t mk_svc(logic [15:0] sr, logic [31:0] pc,
                                              logic [31:0] ssp, logic stopped);
    ies_pkg::ies_in_t d;
    d = random_fields();
    d.cur_sr = sr;
    d.cur_pc = pc;
    d.cur_ssp = ssp;
    d.is_stopped = stopped;
    return d;
  endfunction

  function automatic ies_pkg::ies_in_t mk_reply(logic ok, logic [31:0] rdata,
                                                logic [1:0] vkind, logic [7:0] vnum);
    ies_pkg::ies_in_t d;
    d = random_fields();
    d.bus_ok = ok;
    d.read_data = rdata;
    d.vector_kind = vkind;
    d.vector_number = vnum;
    return d;
  endfunction

  // one beat; sender runs in bursts with idle gaps between them
  task automatic send_beat(input logic [2:0] kind, input ies_pkg::ies_in_t d);
    if (burst_left == 0) begin
      in_tvalid = 1'b0;
      if ($urandom_range(0, 3) != 0) repeat ($urandom_range(1, 6)) @(negedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 12);
    end
    burst_left--;
    in_tuser = kind;
    in_tdata = d;
    in_tvalid = 1'b1;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  // a few requests, a service attempt, then replies that follow the phase,
  // with stray beats thrown in now and then
  task automatic run_entry_attempt();
    int unsigned n;
    logic [15:0] sr;
    logic [2:0]  kind;
    n = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 2);
    if ($urandom_range(0, 15) == 0) n = $urandom_range(3, 9);
    repeat (n) send_beat(ies_pkg::K_REQ, mk_req(4'($urandom), 8'($urandom)));
    sr = 16'($urandom);
    sr[10:8] = ($urandom_range(0, 3) == 0) ? 3'($urandom) : 3'($urandom_range(0, 2));
    send_beat(ies_pkg::K_SVC, mk_svc(sr, $urandom, $urandom, 1'($urandom)));
    while (sb.phase != ies_pkg::PH_IDLE) begin
      if ($urandom_range(0, 9) == 0) begin
        send_beat(3'($urandom_range(0, 7)), random_fields());
      end else begin
        case (sb.phase)
          ies_pkg::PH_ACK:  kind = ies_pkg::K_ACK;
          ies_pkg::PH_READ: kind = ies_pkg::K_READ;
          default:          kind = ies_pkg::K_WDONE;
        endcase
        send_beat(kind, mk_reply($urandom_range(0, 15) != 0, $urandom, 2'($urandom),
                                 8'($urandom)));
      end
    end
  endtask

  initial begin
    sb = new();
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tuser = ies_pkg::K_REQ;
    in_tdata = '0;
    out_tready = 1'b0;
    repeat (12) @(negedge clk);
    rst_n = 1'b1;

    // empty queue, reply out of phase, unused kind
    send_beat(ies_pkg::K_SVC, mk_svc(16'h0000, 32'h0000_1000, 32'h0000_2000, 1'b0));
    send_beat(ies_pkg::K_READ, mk_reply(1'b1, 32'h0, ies_pkg::VK_GIVEN, 8'h00));
    send_beat(K_UNUSED_HI, random_fields());
    // clamp at both ends, fill the queue, then one more is dropped
    send_beat(ies_pkg::K_REQ, mk_req(4'd0, 8'h00));
    send_beat(ies_pkg::K_REQ, mk_req(4'd15, 8'hff));
    send_beat(ies_pkg::K_REQ, mk_req(4'd3, 8'h55));
    send_beat(ies_pkg::K_REQ, mk_req(4'd7, 8'haa));
    send_beat(ies_pkg::K_REQ, mk_req(4'd1, 8'h01));
    send_beat(ies_pkg::K_REQ, mk_req(4'd8, 8'h80));
    send_beat(ies_pkg::K_REQ, mk_req(4'd5, 8'h7f));
    send_beat(ies_pkg::K_REQ, mk_req(4'd2, 8'hfe));
    send_beat(ies_pkg::K_REQ, mk_req(4'd4, 8'h33));
    // level 7 under mask 7 from a stopped core, SSP wraps, T cleared
    send_beat(ies_pkg::K_SVC, mk_svc(16'hffff, 32'hffff_ffff, 32'h0000_0002, 1'b1));
    send_beat(ies_pkg::K_SVC, mk_svc(16'h0000, 32'h0, 32'h0, 1'b0));   // busy, ignored
    send_beat(ies_pkg::K_WDONE, mk_reply(1'b1, 32'h0, ies_pkg::VK_GIVEN, 8'h00));
    send_beat(ies_pkg::K_WDONE, mk_reply(1'b1, 32'h0, ies_pkg::VK_GIVEN, 8'h00));
    send_beat(ies_pkg::K_ACK, mk_reply(1'b1, 32'h0, ies_pkg::VK_AUTO, 8'h00));
    send_beat(ies_pkg::K_READ, mk_reply(1'b1, 32'hdead_beef, ies_pkg::VK_GIVEN, 8'h00));
    // fault on the PC push
    send_beat(ies_pkg::K_SVC, mk_svc(16'h0000, 32'h0, 32'h0, 1'b0));
    send_beat(ies_pkg::K_WDONE, mk_reply(1'b0, 32'h0, ies_pkg::VK_GIVEN, 8'h00));
    // given vector 0xff, fault on the vector read; entry stays queued
    send_beat(ies_pkg::K_SVC, mk_svc(16'h0600, 32'h8000_0001, 32'hffff_fffe, 1'b1));
    send_beat(ies_pkg::K_WDONE, mk_reply(1'b1, 32'h0, ies_pkg::VK_GIVEN, 8'h00));
    send_beat(ies_pkg::K_WDONE, mk_reply(1'b1, 32'h0, ies_pkg::VK_GIVEN, 8'h00));
    send_beat(ies_pkg::K_ACK, mk_reply(1'b1, 32'h0, ies_pkg::VK_GIVEN, 8'hff));
    send_beat(ies_pkg::K_READ, mk_reply(1'b0, 32'hffff_ffff, ies_pkg::VK_GIVEN, 8'h00));

    while (sb.beats < RUN_BEATS) begin
      if ($urandom_range(0, 5) == 0) send_beat(3'($urandom_range(0, 7)), random_fields());
      run_entry_attempt();
    end
    in_tvalid = 1'b0;

    // drain, then give any stray beat time to show up
    while (sb.status_due.size() != 0) @(posedge clk);
    repeat (32) @(posedge clk);

    $display("Sent %0d beats, %0d acting: %0d entries serviced, %0d bus faults,",
             sb.beats, sb.effective, sb.n_done, sb.n_fault);
    $display("%0d requests dropped and %0d service attempts that found nothing to take.",
             sb.n_drop, sb.n_quiet_svc);
    if (sb.errors == 0) begin
      $display("PASS interrupt_entry_sequencer");
    end else begin
      $display("FAIL interrupt_entry_sequencer");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #5_000_000;
    $display("Timed out with %0d status beats outstanding", sb.status_due.size());
    $display("FAIL interrupt_entry_sequencer");
    $finish;
  end

endmodule
